>>> sv/assert_macros.svh
// Assertion helpers used by the top-level RTL file.
// Each macro expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/e2cal_pkg.sv
// ----------------------------------------------------------------------------
// e2cal_pkg
// Field widths, divider reciprocals and month tables for the seconds to
// calendar converter.
// ----------------------------------------------------------------------------
package e2cal_pkg;

  localparam int SEC_W   = 32;
  localparam int DAYS_W  = 16;   // day count since the epoch, max 49710
  localparam int SOD_W   = 17;   // seconds of day, below 86400
  localparam int CYC_W   = 6;    // four-year cycle count, max 34
  localparam int DIC_W   = 11;   // day within a four-year period, below 1461
  localparam int YD_W    = 9;    // day within a year, below 366
  localparam int REM_W   = 12;   // seconds within an hour, below 3600

  localparam int WD_W    = 3;
  localparam int YEAR_W  = 12;
  localparam int MONTH_W = 4;
  localparam int DOM_W   = 5;
  localparam int HOUR_W  = 5;
  localparam int MIN_W   = 6;
  localparam int SECF_W  = 6;

  localparam int OUT_FIELDS_W = WD_W + YEAR_W + MONTH_W + DOM_W + HOUR_W + MIN_W + SECF_W;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam logic [16:0] DAY_SEC     = 17'd86400;
  localparam logic [10:0] CYCLE_DAYS  = 11'd1461;
  localparam logic [11:0] HOUR_SEC    = 12'd3600;
  localparam logic [5:0]  MIN_SEC     = 6'd60;
  localparam logic [11:0] YEAR_BASE   = 12'd1970;
  localparam logic [2:0]  EPOCH_WDAY  = 3'd4;   // 1970-01-01 was a Thursday

  // floor(x / 86400) = (x[31:7] * DAY_RECIP) >> 35
  localparam logic [25:0] DAY_RECIP   = 26'd50903317;
  localparam int          DAY_SHIFT   = 35;
  // floor(d / 1461) = (d * CYCLE_RECIP) >> 27 for d < 2^16
  localparam logic [16:0] CYCLE_RECIP = 17'd91868;
  localparam int          CYCLE_SHIFT = 27;
  // floor(s / 3600) = (s * HOUR_RECIP) >> 29 for s < 2^17
  localparam logic [17:0] HOUR_RECIP  = 18'd149131;
  localparam int          HOUR_SHIFT  = 29;
  // floor(r / 60) = (r * MIN_RECIP) >> 18 for r < 2^12
  localparam logic [12:0] MIN_RECIP   = 13'd4370;
  localparam int          MIN_SHIFT   = 18;

  // Day offsets of the years inside a four-year cycle; the third is leap.
  localparam logic [DIC_W-1:0] YEAR1_START = 11'd365;
  localparam logic [DIC_W-1:0] YEAR2_START = 11'd730;
  localparam logic [DIC_W-1:0] YEAR3_START = 11'd1096;

  typedef logic [YD_W-1:0] month_start_t [12];

  localparam month_start_t COMMON_START = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
    9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
  };
  localparam month_start_t LEAP_START = '{
    9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152,
    9'd182, 9'd213, 9'd244, 9'd274, 9'd305, 9'd335
  };

  localparam logic [MONTH_W-1:0] MONTH_MAX = 4'd11;

endpackage

>>> sv/e2cal_day_split.sv
// ----------------------------------------------------------------------------
// e2cal_day_split
// Splits seconds since the epoch into a day count and seconds of day, and
// derives the weekday. Two register stages.
// ----------------------------------------------------------------------------
module e2cal_day_split import e2cal_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [SEC_W-1:0]  secs,
  output logic [DAYS_W-1:0] days,
  output logic [SOD_W-1:0]  sod,
  output logic [WD_W-1:0]   wday
);

  logic [SEC_W-1:0]  t1_r;
  logic [DAYS_W-1:0] days1_r, days2_r;
  logic [SOD_W-1:0]  sod2_r;
  logic [WD_W-1:0]   wd2_r;

  logic [50:0]       day_prod;
  logic [DAYS_W-1:0] days1_nxt;
  logic [32:0]       day_sec_prod;
  logic [32:0]       sod_full;
  logic [SOD_W-1:0]  wd_arg;

  // x mod 7 by folding octal digits, since 8 = 1 mod 7
  function automatic logic [WD_W-1:0] mod7(input logic [SOD_W-1:0] x);
    logic [5:0] s1;
    logic [3:0] s2;
    logic [3:0] s3;
    s1 = 6'(x[2:0]) + 6'(x[5:3]) + 6'(x[8:6]) + 6'(x[11:9]) + 6'(x[14:12])
       + 6'(x[16:15]);
    s2 = 4'(s1[2:0]) + 4'(s1[5:3]);
    s3 = 4'(s2[2:0]) + 4'(s2[3]);
    if (s3 >= 4'd7) begin
      s3 = s3 - 4'd7;
    end
    return s3[WD_W-1:0];
  endfunction

  assign day_prod  = 51'(secs[SEC_W-1:7]) * 51'(DAY_RECIP);
  assign days1_nxt = day_prod[DAY_SHIFT +: DAYS_W];

  assign day_sec_prod = 33'(days1_r) * 33'(DAY_SEC);
  assign sod_full     = 33'(t1_r) - day_sec_prod;
  assign wd_arg       = 17'(days1_r) + 17'(EPOCH_WDAY);

  always_ff @(posedge clk) begin
    if (en) begin
      t1_r    <= secs;
      days1_r <= days1_nxt;
      days2_r <= days1_r;
      sod2_r  <= sod_full[SOD_W-1:0];
      wd2_r   <= mod7(wd_arg);
    end
  end

  assign days = days2_r;
  assign sod  = sod2_r;
  assign wday = wd2_r;

endmodule

>>> sv/e2cal_date.sv
// ----------------------------------------------------------------------------
// e2cal_date
// Turns a day count into year, month index and day of month using four-year
// cycles of 1461 days. Three register stages, month lookup after the last.
// ----------------------------------------------------------------------------
module e2cal_date import e2cal_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic [DAYS_W-1:0]  days,
  output logic [YEAR_W-1:0]  year,
  output logic [MONTH_W-1:0] month,
  output logic [DOM_W-1:0]   dom
);

  logic [CYC_W-1:0]  cyc3_r, cyc4_r;
  logic [DAYS_W-1:0] days3_r;
  logic [DIC_W-1:0]  dic4_r;
  logic [YEAR_W-1:0] yr5_r;
  logic [YD_W-1:0]   yd5_r;
  logic              leap5_r;

  logic [32:0]       cyc_prod;
  logic [16:0]       cyc_days;
  logic [DAYS_W-1:0] dic_full;
  logic [1:0]        yidx_nxt;
  logic [DIC_W-1:0]  yd_nxt;
  logic              leap_nxt;
  logic [YEAR_W-1:0] yr_nxt;

  month_start_t      starts;
  logic [3:0]        mcnt;
  logic [YD_W-1:0]   dom_full;

  assign cyc_prod = 33'(days) * 33'(CYCLE_RECIP);
  assign cyc_days = 17'(cyc3_r) * 17'(CYCLE_DAYS);
  assign dic_full = days3_r - cyc_days[DAYS_W-1:0];

  always_comb begin
    leap_nxt = 1'b0;
    if (dic4_r < YEAR1_START) begin
      yidx_nxt = 2'd0;
      yd_nxt   = dic4_r;
    end else if (dic4_r < YEAR2_START) begin
      yidx_nxt = 2'd1;
      yd_nxt   = dic4_r - YEAR1_START;
    end else if (dic4_r < YEAR3_START) begin
      yidx_nxt = 2'd2;
      yd_nxt   = dic4_r - YEAR2_START;
      leap_nxt = 1'b1;
    end else begin
      yidx_nxt = 2'd3;
      yd_nxt   = dic4_r - YEAR3_START;
    end
    yr_nxt = YEAR_BASE + 12'({cyc4_r, yidx_nxt});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cyc3_r  <= cyc_prod[CYCLE_SHIFT +: CYC_W];
      days3_r <= days;
      cyc4_r  <= cyc3_r;
      dic4_r  <= dic_full[DIC_W-1:0];
      yr5_r   <= yr_nxt;
      yd5_r   <= yd_nxt[YD_W-1:0];
      leap5_r <= leap_nxt;
    end
  end

  // Month = number of later month starts already passed.
  always_comb begin
    starts = leap5_r ? LEAP_START : COMMON_START;
    mcnt   = 4'd0;
    for (int i = 1; i < 12; i++) begin
      if (yd5_r >= starts[i]) begin
        mcnt = mcnt + 4'd1;
      end
    end
    dom_full = yd5_r - starts[mcnt] + 9'd1;
  end

  assign year  = yr5_r;
  assign month = mcnt;
  assign dom   = dom_full[DOM_W-1:0];

endmodule

>>> sv/e2cal_time.sv
// ----------------------------------------------------------------------------
// e2cal_time
// Splits seconds of day into hour, minute and second. Three register stages,
// the second is finished after the last.
// ----------------------------------------------------------------------------
module e2cal_time import e2cal_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [SOD_W-1:0]  sod,
  output logic [HOUR_W-1:0] hour,
  output logic [MIN_W-1:0]  minute,
  output logic [SECF_W-1:0] second
);

  logic [HOUR_W-1:0] hr3_r, hr4_r, hr5_r;
  logic [SOD_W-1:0]  sod3_r;
  logic [REM_W-1:0]  rem4_r, rem5_r;
  logic [MIN_W-1:0]  mi5_r;

  logic [34:0]       hr_prod;
  logic [16:0]       hr_secs;
  logic [SOD_W-1:0]  rem_full;
  logic [24:0]       mi_prod;
  logic [REM_W-1:0]  mi_secs;
  logic [REM_W-1:0]  se_full;

  assign hr_prod  = 35'(sod) * 35'(HOUR_RECIP);
  assign hr_secs  = 17'(hr3_r) * 17'(HOUR_SEC);
  assign rem_full = sod3_r - hr_secs;
  assign mi_prod  = 25'(rem4_r) * 25'(MIN_RECIP);

  always_ff @(posedge clk) begin
    if (en) begin
      hr3_r  <= hr_prod[HOUR_SHIFT +: HOUR_W];
      sod3_r <= sod;
      hr4_r  <= hr3_r;
      rem4_r <= rem_full[REM_W-1:0];
      hr5_r  <= hr4_r;
      rem5_r <= rem4_r;
      mi5_r  <= mi_prod[MIN_SHIFT +: MIN_W];
    end
  end

  assign mi_secs = 12'(mi5_r) * 12'(MIN_SEC);
  assign se_full = rem5_r - mi_secs;

  assign hour   = hr5_r;
  assign minute = mi5_r;
  assign second = se_full[SECF_W-1:0];

endmodule

>>> sv/epoch_seconds_to_calendar.sv
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar
// Converts seconds since 1970-01-01 00:00:00 into weekday, year, month, day
// of month, hour, minute and second (plain every-fourth-year leap rule).
//
// Input: one 32-bit seconds count per transaction on in_tvalid/in_tready.
// Output: one calendar result per input transaction on out_tvalid/out_tready,
// in input order.
// Stages: input register, five arithmetic stages, output register. Throughput:
// one transaction per cycle unless stalled; in each stage, the day, date and
// time paths each hold at most one multiply by a constant reciprocal.
// Stall: the whole pipeline advances together; while a result sits in the
// output register and out_tready is low, every stage holds and in_tready
// drops. In-flight items are never lost or duplicated.
// Reset: rst_n clears all stage valid flags and the output valid flag; the
// data registers are not reset.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module epoch_seconds_to_calendar import e2cal_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [SEC_W-1:0]      in_tdata,   // [31:0] epoch_seconds
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [2:0] weekday, [14:3] year, [18:15] month, [23:19] day_of_month,
  // [28:24] hour, [34:29] minute, [40:35] second, [47:41] zero
  output logic [OUT_DATA_W-1:0] out_tdata
);

  localparam int STAGES = 6;

  logic                  en;
  logic [STAGES-1:0]     v_r, v_nxt;
  logic                  out_valid_r;
  logic [SEC_W-1:0]      t0_r;
  logic [WD_W-1:0]       wd3_r, wd4_r, wd5_r;

  logic [DAYS_W-1:0]     days2;
  logic [SOD_W-1:0]      sod2;
  logic [WD_W-1:0]       wd2;
  logic [YEAR_W-1:0]     year5;
  logic [MONTH_W-1:0]    month5;
  logic [DOM_W-1:0]      dom5;
  logic [HOUR_W-1:0]     hour5;
  logic [MIN_W-1:0]      min5;
  logic [SECF_W-1:0]     sec5;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic                  time_ok;
  logic                  date_ok;

  // Advance every stage unless a finished result is waiting on the receiver.
  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;
  assign v_nxt     = {v_r[STAGES-2:0], in_tvalid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v_r         <= v_nxt;
      out_valid_r <= v_r[STAGES-1];
    end
  end

  e2cal_day_split u_split (
    .clk  (clk),
    .en   (en),
    .secs (t0_r),
    .days (days2),
    .sod  (sod2),
    .wday (wd2)
  );

  e2cal_date u_date (
    .clk   (clk),
    .en    (en),
    .days  (days2),
    .year  (year5),
    .month (month5),
    .dom   (dom5)
  );

  e2cal_time u_time (
    .clk    (clk),
    .en     (en),
    .sod    (sod2),
    .hour   (hour5),
    .minute (min5),
    .second (sec5)
  );

  assign out_data_nxt = OUT_DATA_W'({sec5, min5, hour5, dom5, month5, year5, wd5_r});

  always_ff @(posedge clk) begin
    if (en) begin
      t0_r       <= in_tdata;
      wd3_r      <= wd2;
      wd4_r      <= wd3_r;
      wd5_r      <= wd4_r;
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign time_ok = (out_data_r[28:24] <= 5'd23) && (out_data_r[34:29] <= 6'd59) &&
                   (out_data_r[40:35] <= 6'd59);
  assign date_ok = (out_data_r[18:15] <= MONTH_MAX) && (out_data_r[23:19] != 5'd0) &&
                   (out_data_r[14:3] >= YEAR_BASE) && (out_data_r[14:3] <= 12'd2106);

  `ASSERT_IMPL(a_sod_range, v_r[2], sod2 < DAY_SEC, "seconds of day out of range")
  `ASSERT_IMPL(a_time_range, out_valid_r, time_ok, "time field out of range")
  `ASSERT_IMPL(a_date_range, out_valid_r, date_ok, "date field out of range")
  `ASSERT_NEXT(a_stall_hold, !en, $stable(v_r) && out_valid_r, "pipeline moved during stall")

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for epoch_seconds_to_calendar. A queue of seconds
// counts (edge values first, then random, near-midnight and range-end times)
// feeds a clocked driver; a clocked monitor compares every result field by
// field against a calendar predicted at input acceptance. Both sides insert
// random gaps and stalls, with bursts of back-to-back traffic.
// ----------------------------------------------------------------------------
module tb import e2cal_pkg::*; ;

  localparam int IDLE_LIMIT   = 2000;  // cycles without any transaction
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_ITEMS = 1026;
  localparam int PRINT_LIMIT  = 50;
  localparam int PAD_W        = OUT_DATA_W - OUT_FIELDS_W;

  typedef struct {
    logic [WD_W-1:0]    weekday;
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DOM_W-1:0]   day_of_month;
    logic [HOUR_W-1:0]  hour;
    logic [MIN_W-1:0]   minute;
    logic [SECF_W-1:0]  second;
    logic [PAD_W-1:0]   pad;
  } calendar_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [SEC_W-1:0]      in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  logic [SEC_W-1:0] pending_secs_q [$];
  calendar_t        exp_cal_q [$];
  logic [SEC_W-1:0] exp_secs_q [$];

  int mismatch_cnt = 0;
  int sent_cnt = 0;
  int checked_cnt = 0;
  int idle_cycles = 0;
  int src_gap = 0;
  int src_burst = 0;
  int sink_wait = 0;
  int sink_burst = 0;

  epoch_seconds_to_calendar dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  // Plain every-fourth-year calendar; the third year of each 1461-day cycle is leap.
  function automatic calendar_t predict_calendar(logic [SEC_W-1:0] secs);
    int unsigned mlen [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    calendar_t   c;
    int unsigned days, sod, cyc, dic, yday, yoff, mon, dom;
    bit          found;
    days = secs / 32'd86400;
    sod  = secs % 32'd86400;
    cyc  = days / 1461;
    dic  = days % 1461;
    if (dic < 365) begin
      yoff = 0;
      yday = dic;
    end else if (dic < 730) begin
      yoff = 1;
      yday = dic - 365;
    end else if (dic < 1096) begin
      yoff = 2;
      yday = dic - 730;
      mlen[1] = 29;
    end else begin
      yoff = 3;
      yday = dic - 1096;
    end
    mon = 11;
    dom = 30;
    found = 1'b0;
    for (int m = 0; m < 12; m++) begin
      if (!found) begin
        if (yday < mlen[m]) begin
          mon = m;
          dom = yday;
          found = 1'b1;
        end else begin
          yday -= mlen[m];
        end
      end
    end
    if (dom > 30) dom = 30;
    c.weekday      = WD_W'((days + 4) % 7);
    c.year         = YEAR_W'(1970 + cyc * 4 + yoff);
    c.month        = MONTH_W'(mon);
    c.day_of_month = DOM_W'(dom + 1);
    c.hour         = HOUR_W'(sod / 3600);
    c.minute       = MIN_W'((sod % 3600) / 60);
    c.second       = SECF_W'(sod % 60);
    c.pad          = '0;
    return c;
  endfunction

  function automatic calendar_t unpack_calendar(logic [OUT_DATA_W-1:0] d);
    calendar_t c;
    c.weekday      = d[2:0];
    c.year         = d[14:3];
    c.month        = d[18:15];
    c.day_of_month = d[23:19];
    c.hour         = d[28:24];
    c.minute       = d[34:29];
    c.second       = d[40:35];
    c.pad          = d[OUT_DATA_W-1:41];
    return c;
  endfunction

  // Random wait before the next transaction, with occasional bursts of no waiting.
  function automatic int draw_wait(inout int burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      burst = $urandom_range(20, 60);
      return 0;
    end
    return $urandom_range(0, 8);
  endfunction

  task automatic report_mismatch(string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= PRINT_LIMIT) $display("[%0t] MISMATCH: %s", $time, msg);
  endtask

  task automatic check_field(string name, logic [SEC_W-1:0] secs, int unsigned want,
                             int unsigned got);
    if (want != got) begin
      report_mismatch($sformatf("%s for %0d s: expected %0d, got %0d",
                                name, secs, want, got));
    end
  endtask

  // Driver: predict on each accepted transaction, then present the next item after its gap.
  always @(posedge clk) begin : driver
    int gap_n;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        exp_cal_q.push_back(predict_calendar(in_tdata));
        exp_secs_q.push_back(in_tdata);
        sent_cnt++;
      end
      if (!in_tvalid || in_tready) begin
        if (src_gap != 0) begin
          src_gap <= src_gap - 1;
          in_tvalid <= 1'b0;
        end else if (pending_secs_q.size() != 0) begin
          in_tdata <= pending_secs_q.pop_front();
          in_tvalid <= 1'b1;
          gap_n = draw_wait(src_burst);
          src_gap <= gap_n;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each accepted result against the oldest prediction, then stall at random.
  always @(posedge clk) begin : monitor
    calendar_t        got, want;
    logic [SEC_W-1:0] secs;
    int               wait_n;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = unpack_calendar(out_tdata);
        if (exp_cal_q.size() == 0) begin
          report_mismatch($sformatf("result %h with no pending input", out_tdata));
        end else begin
          want = exp_cal_q.pop_front();
          secs = exp_secs_q.pop_front();
          check_field("weekday", secs, 32'(want.weekday), 32'(got.weekday));
          check_field("year", secs, 32'(want.year), 32'(got.year));
          check_field("month", secs, 32'(want.month), 32'(got.month));
          check_field("day_of_month", secs, 32'(want.day_of_month),
                      32'(got.day_of_month));
          check_field("hour", secs, 32'(want.hour), 32'(got.hour));
          check_field("minute", secs, 32'(want.minute), 32'(got.minute));
          check_field("second", secs, 32'(want.second), 32'(got.second));
          check_field("padding", secs, 32'(want.pad), 32'(got.pad));
          checked_cnt++;
        end
        wait_n = draw_wait(sink_burst);
        sink_wait <= wait_n;
        out_tready <= (wait_n == 0);
      end else if (sink_wait != 0) begin
        sink_wait <= sink_wait - 1;
        out_tready <= (sink_wait == 1);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles == IDLE_LIMIT) begin
        $display("Timeout: no transaction for %0d cycles", IDLE_LIMIT);
        $display("Mismatches found");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin : stimulus
    int          kind;
    int unsigned day;
    logic [31:0] secs;
    // Field extremes, minute/hour/day/year/cycle rollovers, leap days, the 2038
    // sign boundary, a plain-rule leap day in 2100 and the top of the range.
    pending_secs_q = '{
      32'd0, 32'd1, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399, 32'd86400,
      32'd31535999, 32'd31536000, 32'd68169599, 32'd68169600, 32'd94694399,
      32'd94694400, 32'd126230399, 32'd126230400, 32'd951782400, 32'd4107542400,
      32'd2147483647, 32'd2147483648, 32'hAAAAAAAA, 32'h55555555,
      32'hFFFFFFFE, 32'hFFFFFFFF
    };
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      kind = $urandom_range(0, 7);
      if (kind <= 3) begin
        secs = $urandom;
      end else if (kind <= 5) begin
        // Hit day, month and year rollovers.
        day = $urandom_range(0, 49709);
        case ($urandom_range(0, 2))
          0:       secs = day * 32'd86400;
          1:       secs = day * 32'd86400 + 32'd86399;
          default: secs = day * 32'd86400 + $urandom_range(0, 86399);
        endcase
      end else if (kind == 6) begin
        secs = 32'hFFFFFFFF - $urandom_range(0, 2000000);
      end else begin
        secs = $urandom_range(0, 252460800);
      end
      pending_secs_q.push_back(secs);
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_secs_q.size() != 0 || in_tvalid || exp_cal_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Summary: %0d timestamps converted, %0d results checked field by field.",
             sent_cnt, checked_cnt);
    $display("Covered edge times, near-midnight and range-end values under random gaps/stalls.");
    if (mismatch_cnt == 0 && exp_cal_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+sv
sv/e2cal_pkg.sv
sv/e2cal_day_split.sv
sv/e2cal_date.sv
sv/e2cal_time.sv
sv/epoch_seconds_to_calendar.sv
tb/tb.sv
